>>> sv/ptks_pkg.sv
package ptks_pkg;

    // Field widths of the stream words.
    localparam int OP_W  = 2;
    localparam int SCORE_W = 32;
    localparam int DOC_W = 16;
    localparam int K_W   = 5;
    localparam int KIND_W = 2;

    // Defaults of the top level parameters.
    localparam int MAX_KEPT_DEF   = 16;
    localparam int DOC_COUNT_DEF  = 65536;
    localparam int SCORE_BITS_DEF = 32;

    // Seen map organization: one row of flags per memory word, tagged with a query epoch.
    localparam int DOC_SPACE     = 1 << DOC_W;
    localparam int SEEN_ROW_BITS = 64;
    localparam int SEEN_ROWS_DEF = DOC_SPACE / SEEN_ROW_BITS;
    localparam int EPOCH_BITS    = 8;

    localparam logic [K_W-1:0] TOP_COUNT_RESET = 5'd10;

    localparam logic [OP_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLAIM  = 2'd1;
    localparam logic [OP_W-1:0] OP_OFFER  = 2'd2;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd3;

    localparam logic [KIND_W-1:0] KIND_BLOCK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLAIM  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OFFER  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RANKED = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SCORE_W-1:0] score;
        logic [DOC_W-1:0]   doc_id;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic               flag;
        logic [SCORE_W-1:0] threshold;
        logic [SCORE_W-1:0] rank_score;
        logic [DOC_W-1:0]   rank_doc;
        logic               entry_valid;
        logic               last;
    } result_t;

    typedef struct packed {
        logic insert;
        logic shift_up;
    } cell_ctrl_t;

    typedef struct packed {
        logic rd_en;
        logic commit;
        logic new_query;
    } seen_ctrl_t;

    typedef struct packed {
        logic fresh;
        logic busy;
    } seen_stat_t;

endpackage

>>> sv/ptks_stream_if.sv
interface ptks_stream_if #(
    parameter type T = ptks_pkg::item_t
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/ptks_cell.sv
module ptks_cell #(
    parameter int SCORE_BITS = ptks_pkg::SCORE_BITS_DEF
) (
    input  logic                        clk,
    input  ptks_pkg::cell_ctrl_t        ctrl,
    input  logic                        occupied,
    input  logic [SCORE_BITS-1:0]       new_score,
    input  logic [ptks_pkg::DOC_W-1:0]  new_doc,
    input  logic                        above_gt,
    input  logic [SCORE_BITS-1:0]       above_score,
    input  logic [ptks_pkg::DOC_W-1:0]  above_doc,
    input  logic [SCORE_BITS-1:0]       below_score,
    input  logic [ptks_pkg::DOC_W-1:0]  below_doc,
    output logic                        gt,
    output logic [SCORE_BITS-1:0]       score,
    output logic [ptks_pkg::DOC_W-1:0]  doc,
    output logic [SCORE_BITS-1:0]       score_next
);

    logic [SCORE_BITS-1:0]      score_reg;
    logic [ptks_pkg::DOC_W-1:0] doc_reg;
    logic [ptks_pkg::DOC_W-1:0] doc_next;

    // An empty cell ranks below every candidate, so the new word lands at the first such place.
    assign gt = !occupied || (new_score > score_reg) ||
                ((new_score == score_reg) && (new_doc > doc_reg));

    always_comb
    begin
        score_next = score_reg;
        doc_next   = doc_reg;
        if (ctrl.shift_up)
        begin
            score_next = below_score;
            doc_next   = below_doc;
        end
        else if (ctrl.insert)
        begin
            if (above_gt)
            begin
                score_next = above_score;
                doc_next   = above_doc;
            end
            else if (gt)
            begin
                score_next = new_score;
                doc_next   = new_doc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        score_reg <= score_next;
        doc_reg   <= doc_next;
    end

    assign score = score_reg;
    assign doc   = doc_reg;

endmodule

>>> sv/ptks_seen_map.sv
module ptks_seen_map #(
    parameter int ROW_COUNT = ptks_pkg::SEEN_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ptks_pkg::seen_ctrl_t        ctrl,
    input  logic [ptks_pkg::DOC_W-1:0]  doc,
    output ptks_pkg::seen_stat_t        stat
);

    localparam int ROW_BITS = ptks_pkg::SEEN_ROW_BITS;
    localparam int EP_W     = ptks_pkg::EPOCH_BITS;
    localparam int BIT_AW   = $clog2(ROW_BITS);
    localparam int ROW_AW   = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int WORD_W   = EP_W + ROW_BITS;

    logic [WORD_W-1:0]   mem [ROW_COUNT];
    logic [WORD_W-1:0]   rd_word_reg;
    logic [ROW_AW-1:0]   row_reg;
    logic [BIT_AW-1:0]   bit_reg;

    logic [EP_W-1:0]     epoch_reg;
    logic [EP_W-1:0]     epoch_next;
    logic                clr_active_reg;
    logic                clr_active_next;
    logic [ROW_AW-1:0]   clr_addr_reg;
    logic [ROW_AW-1:0]   clr_addr_next;

    logic [ROW_BITS-1:0] cur_bits;
    logic                wr_en;
    logic [ROW_AW-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;

    // A row written in an earlier query carries an old epoch and reads as all clear.
    assign cur_bits = (rd_word_reg[WORD_W-1 -: EP_W] == epoch_reg) ?
                      rd_word_reg[ROW_BITS-1:0] : '0;

    assign stat.fresh = !cur_bits[bit_reg];
    assign stat.busy  = clr_active_reg;

    assign wr_en   = clr_active_reg || ctrl.commit;
    assign wr_addr = clr_active_reg ? clr_addr_reg : row_reg;
    assign wr_data = clr_active_reg ? '0 :
                     {epoch_reg, cur_bits | (ROW_BITS'(1) << bit_reg)};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en)
        begin
            rd_word_reg <= mem[doc[BIT_AW +: ROW_AW]];
            row_reg     <= doc[BIT_AW +: ROW_AW];
            bit_reg     <= doc[BIT_AW-1:0];
        end
    end

    always_comb
    begin
        epoch_next      = epoch_reg;
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            if (clr_addr_reg == ROW_AW'(ROW_COUNT - 1))
            begin
                clr_active_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + ROW_AW'(1);
            end
        end
        if (ctrl.new_query)
        begin
            // When the epoch would wrap, old tags could alias, so the rows are swept instead.
            if (epoch_reg == '1)
            begin
                epoch_next      = '0;
                clr_active_next = 1'b1;
                clr_addr_next   = '0;
            end
            else
            begin
                epoch_next = epoch_reg + EP_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            epoch_reg      <= '0;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else
        begin
            epoch_reg      <= epoch_next;
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
        end
    end

endmodule

>>> sv/pruned_top_k_selector_top.sv
// A check or an offer is taken one per cycle while results are taken and has its result word
// registered in the cycle after; a claim in range reads its seen-map row, then writes it back as
// its result word is registered; a finish gives one ranked word per cycle while results are taken,
// from the head of the cell row, n for n kept entries (one empty word for none). No word is
// taken during a claim or a finish. Reset: asynchronous, active low; clears control state, then
// sweeps the ROW_COUNT seen-map rows (1024 by default), taking no word, as after each 256th finish.
module pruned_top_k_selector_top #(
    parameter int MAX_KEPT   = ptks_pkg::MAX_KEPT_DEF,
    parameter int DOC_COUNT  = ptks_pkg::DOC_COUNT_DEF,
    parameter int SCORE_BITS = ptks_pkg::SCORE_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    ptks_stream_if.sink                item,
    ptks_stream_if.source              result,
    input  logic                       cfg_we,
    input  logic [ptks_pkg::K_W-1:0]   cfg_wdata
);

    localparam int CNT_W     = $clog2(MAX_KEPT + 1);
    localparam int IDX_W     = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CMP_W     = (CNT_W > ptks_pkg::K_W) ? CNT_W : ptks_pkg::K_W;
    localparam int DOC_SPAN  = (DOC_COUNT < ptks_pkg::DOC_SPACE) ? DOC_COUNT :
                               ptks_pkg::DOC_SPACE;
    localparam int ROW_RAW   = (DOC_SPAN + ptks_pkg::SEEN_ROW_BITS - 1) /
                               ptks_pkg::SEEN_ROW_BITS;
    localparam int ROW_COUNT = (ROW_RAW > 2) ? ROW_RAW : 2;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLAIM = 2'd1;
    localparam logic [1:0] ST_RANK  = 2'd2;

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [ptks_pkg::K_W-1:0]   top_count_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [SCORE_BITS-1:0]      thr_reg;
    logic [SCORE_BITS-1:0]      thr_next;
    logic                       claim_hit_reg;
    logic                       claim_hit_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    ptks_pkg::result_t          out_word_reg;
    ptks_pkg::result_t          out_word_next;
    ptks_pkg::result_t          res;

    logic [SCORE_BITS-1:0]      score_sat;
    logic                       doc_in_range;
    logic [CMP_W-1:0]           top_count_ext;
    logic [CMP_W-1:0]           k_eff;
    logic                       below_k;
    logic                       offer_take;
    logic                       out_free;
    logic                       accept;
    logic [CNT_W-1:0]           wk_full;
    logic [IDX_W-1:0]           wk_idx;
    logic [SCORE_BITS-1:0]      thr_calc;

    ptks_pkg::cell_ctrl_t       cell_ctrl;
    ptks_pkg::seen_ctrl_t       seen_ctrl;
    ptks_pkg::seen_stat_t       seen_stat;

    logic [SCORE_BITS-1:0]      cell_score [MAX_KEPT];
    logic [SCORE_BITS-1:0]      cell_score_next [MAX_KEPT];
    logic [ptks_pkg::DOC_W-1:0] cell_doc [MAX_KEPT];
    logic                       cell_gt [MAX_KEPT];

    if (SCORE_BITS < ptks_pkg::SCORE_W)
    begin : g_sat
        assign score_sat = (|item.data.score[ptks_pkg::SCORE_W-1:SCORE_BITS]) ? '1 :
                           item.data.score[SCORE_BITS-1:0];
    end
    else
    begin : g_wide
        assign score_sat = SCORE_BITS'(item.data.score);
    end

    assign doc_in_range = (DOC_COUNT >= ptks_pkg::DOC_SPACE) ||
                          (32'(item.data.doc_id) < 32'(DOC_COUNT));

    always_comb
    begin
        top_count_ext = CMP_W'(top_count_reg);
        if (top_count_ext == '0)
        begin
            k_eff = CMP_W'(1);
        end
        else if (top_count_ext > CMP_W'(MAX_KEPT))
        begin
            k_eff = CMP_W'(MAX_KEPT);
        end
        else
        begin
            k_eff = top_count_ext;
        end
    end

    // The row is kept sorted best first, so the weakest entry sits at count - 1.
    assign below_k    = CMP_W'(count_reg) < k_eff;
    assign offer_take = below_k || ((count_reg != '0) && (score_sat > thr_reg));

    assign out_free     = !out_valid_reg || result.ready;
    assign item.ready   = (state_reg == ST_IDLE) && !seen_stat.busy && out_free;
    assign accept       = item.valid && item.ready;
    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

    always_comb
    begin
        cell_ctrl.insert   = accept && (item.data.op == ptks_pkg::OP_OFFER) && offer_take;
        cell_ctrl.shift_up = (state_reg == ST_RANK) && out_free;
    end

    assign wk_full  = below_k ? count_reg : count_reg - CNT_W'(1);
    assign wk_idx   = wk_full[IDX_W-1:0];
    assign thr_calc = cell_score_next[wk_idx];

    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_cell
        logic                       occupied;
        logic                       above_gt;
        logic [SCORE_BITS-1:0]      above_score;
        logic [ptks_pkg::DOC_W-1:0] above_doc;
        logic [SCORE_BITS-1:0]      below_score;
        logic [ptks_pkg::DOC_W-1:0] below_doc;

        assign occupied = CNT_W'(i) < count_reg;

        if (i == 0)
        begin : g_head
            assign above_gt    = 1'b0;
            assign above_score = score_sat;
            assign above_doc   = item.data.doc_id;
        end
        else
        begin : g_up
            assign above_gt    = cell_gt[i-1];
            assign above_score = cell_score[i-1];
            assign above_doc   = cell_doc[i-1];
        end

        if (i == MAX_KEPT - 1)
        begin : g_tail
            assign below_score = cell_score[i];
            assign below_doc   = cell_doc[i];
        end
        else
        begin : g_down
            assign below_score = cell_score[i+1];
            assign below_doc   = cell_doc[i+1];
        end

        ptks_cell #(
            .SCORE_BITS (SCORE_BITS)
        ) u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .occupied    (occupied),
            .new_score   (score_sat),
            .new_doc     (item.data.doc_id),
            .above_gt    (above_gt),
            .above_score (above_score),
            .above_doc   (above_doc),
            .below_score (below_score),
            .below_doc   (below_doc),
            .gt          (cell_gt[i]),
            .score       (cell_score[i]),
            .doc         (cell_doc[i]),
            .score_next  (cell_score_next[i])
        );
    end

    ptks_seen_map #(
        .ROW_COUNT (ROW_COUNT)
    ) u_seen_map (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (seen_ctrl),
        .doc   (item.data.doc_id),
        .stat  (seen_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        thr_next       = thr_reg;
        claim_hit_next = claim_hit_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_word_next  = out_word_reg;
        seen_ctrl      = '0;
        res            = '0;
        res.threshold  = ptks_pkg::SCORE_W'(thr_reg);
        res.last       = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.data.op)
                        ptks_pkg::OP_CHECK:
                        begin
                            res.kind       = ptks_pkg::KIND_BLOCK;
                            res.flag       = score_sat >= thr_reg;
                            out_valid_next = 1'b1;
                            out_word_next  = res;
                        end
                        ptks_pkg::OP_CLAIM:
                        begin
                            seen_ctrl.rd_en = doc_in_range;
                            claim_hit_next  = doc_in_range;
                            state_next      = ST_CLAIM;
                        end
                        ptks_pkg::OP_OFFER:
                        begin
                            if (offer_take)
                            begin
                                thr_next = thr_calc;
                                if (below_k)
                                begin
                                    count_next = count_reg + CNT_W'(1);
                                end
                            end
                            res.kind       = ptks_pkg::KIND_OFFER;
                            res.flag       = offer_take;
                            res.threshold  = ptks_pkg::SCORE_W'(thr_next);
                            out_valid_next = 1'b1;
                            out_word_next  = res;
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                res.kind            = ptks_pkg::KIND_RANKED;
                                out_valid_next      = 1'b1;
                                out_word_next       = res;
                                seen_ctrl.new_query = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_RANK;
                            end
                        end
                    endcase
                end
            end
            ST_CLAIM:
            begin
                if (out_free)
                begin
                    seen_ctrl.commit = claim_hit_reg;
                    res.kind         = ptks_pkg::KIND_CLAIM;
                    res.flag         = claim_hit_reg && seen_stat.fresh;
                    out_valid_next   = 1'b1;
                    out_word_next    = res;
                    state_next       = ST_IDLE;
                end
            end
            ST_RANK:
            begin
                // The head cell holds the best remaining entry; the row shifts up behind it.
                if (out_free)
                begin
                    res.kind        = ptks_pkg::KIND_RANKED;
                    res.rank_score  = ptks_pkg::SCORE_W'(cell_score[0]);
                    res.rank_doc    = cell_doc[0];
                    res.entry_valid = 1'b1;
                    res.last        = count_reg == CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_word_next   = res;
                    count_next      = count_reg - CNT_W'(1);
                    if (count_reg == CNT_W'(1))
                    begin
                        thr_next            = '0;
                        seen_ctrl.new_query = 1'b1;
                        state_next          = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            top_count_reg <= ptks_pkg::TOP_COUNT_RESET;
            count_reg     <= '0;
            thr_reg       <= '0;
            claim_hit_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            thr_reg       <= thr_next;
            claim_hit_reg <= claim_hit_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                top_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

>>> tb/sv/tb_pruned_top_k_selector_top.sv
`timescale 1ns / 100ps

module tb_pruned_top_k_selector_top;

    localparam int KEEP_SLOTS    = ptks_pkg::MAX_KEPT_DEF;
    localparam int RUN_LIMIT     = 1000000;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_WORDS   = 30;

    // Values of k for the random phases; 0 and 17 and above exercise the clamping.
    localparam logic [ptks_pkg::K_W-1:0] K_PLAN [10] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3,
                                                         5'd17, 5'd2, 5'd12, 5'd10, 5'd7};

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_we;
    logic [ptks_pkg::K_W-1:0] cfg_wdata;

    ptks_stream_if #(.T(ptks_pkg::item_t))   item_ch ();
    ptks_stream_if #(.T(ptks_pkg::result_t)) result_ch ();

    pruned_top_k_selector_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    ptks_pkg::item_t   pending_words[$];
    ptks_pkg::result_t awaited_words[$];

    // Shadow copy of the selector state.
    logic [ptks_pkg::SCORE_W-1:0] kept_score [KEEP_SLOTS];
    logic [ptks_pkg::DOC_W-1:0]   kept_doc [KEEP_SLOTS];
    int                           kept_n = 0;
    logic [ptks_pkg::K_W-1:0]     top_k = ptks_pkg::TOP_COUNT_RESET;
    bit                           seen_doc [ptks_pkg::DOC_SPACE];

    bit idle_on = 1'b1;
    bit hold_armed = 1'b0;
    bit hold_done;
    int hold_left;
    int gap_left;
    int stall_left;
    int stall_next;
    int items_taken = 0;
    int words_checked;
    int finishes_taken = 0;
    int fault_count = 0;
    int cycle_count;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int draw_wait();
        return idle_on ? $urandom_range(0, 4) : 0;
    endfunction

    function automatic bit pair_below(logic [ptks_pkg::SCORE_W-1:0] sa,
                                      logic [ptks_pkg::DOC_W-1:0] da,
                                      logic [ptks_pkg::SCORE_W-1:0] sb,
                                      logic [ptks_pkg::DOC_W-1:0] db);
        return (sa < sb) || (sa == sb && da < db);
    endfunction

    function automatic int weakest_slot();
        int w;
        w = 0;
        for (int i = 1; i < kept_n; i++)
            if (pair_below(kept_score[i], kept_doc[i], kept_score[w], kept_doc[w]))
                w = i;
        return w;
    endfunction

    function automatic logic [ptks_pkg::SCORE_W-1:0] entry_floor();
        return (kept_n == 0) ? '0 : kept_score[weakest_slot()];
    endfunction

    function automatic int keep_limit();
        if (top_k == 0)
            return 1;
        if (top_k > KEEP_SLOTS)
            return KEEP_SLOTS;
        return int'(top_k);
    endfunction

    function automatic ptks_pkg::result_t make_word(logic [ptks_pkg::KIND_W-1:0] kind,
                                                    logic flag,
                                                    logic [ptks_pkg::SCORE_W-1:0] floor_v,
                                                    logic [ptks_pkg::SCORE_W-1:0] rs,
                                                    logic [ptks_pkg::DOC_W-1:0] rd,
                                                    logic ev, logic last);
        ptks_pkg::result_t r;
        r.kind        = kind;
        r.flag        = flag;
        r.threshold   = floor_v;
        r.rank_score  = rs;
        r.rank_doc    = rd;
        r.entry_valid = ev;
        r.last        = last;
        return r;
    endfunction

    task automatic await_word(ptks_pkg::result_t r);
        awaited_words = {awaited_words, r};
    endtask

    // Updates the shadow state for one accepted word and queues the result words it causes.
    task automatic track_query(ptks_pkg::item_t w);
        logic [ptks_pkg::SCORE_W-1:0] floor_v;
        logic [ptks_pkg::SCORE_W-1:0] srt_s [KEEP_SLOTS];
        logic [ptks_pkg::DOC_W-1:0]   srt_d [KEEP_SLOTS];
        logic [ptks_pkg::SCORE_W-1:0] ts;
        logic [ptks_pkg::DOC_W-1:0]   td;
        bit                           hit;
        int                           b;
        int                           slot;
        hit = 1'b0;
        case (w.op)
            ptks_pkg::OP_CHECK:
            begin
                floor_v = entry_floor();
                await_word(make_word(ptks_pkg::KIND_BLOCK, w.score >= floor_v, floor_v,
                                     '0, '0, 1'b0, 1'b1));
            end
            ptks_pkg::OP_CLAIM:
            begin
                hit = !seen_doc[w.doc_id];
                seen_doc[w.doc_id] = 1'b1;
                await_word(make_word(ptks_pkg::KIND_CLAIM, hit, entry_floor(),
                                     '0, '0, 1'b0, 1'b1));
            end
            ptks_pkg::OP_OFFER:
            begin
                if (kept_n < keep_limit())
                begin
                    kept_score[kept_n] = w.score;
                    kept_doc[kept_n]   = w.doc_id;
                    kept_n++;
                    hit = 1'b1;
                end
                else if (kept_n > 0)
                begin
                    // Only a strictly greater score displaces the weakest entry.
                    slot = weakest_slot();
                    if (w.score > kept_score[slot])
                    begin
                        kept_score[slot] = w.score;
                        kept_doc[slot]   = w.doc_id;
                        hit = 1'b1;
                    end
                end
                await_word(make_word(ptks_pkg::KIND_OFFER, hit, entry_floor(),
                                     '0, '0, 1'b0, 1'b1));
            end
            default:
            begin
                floor_v = entry_floor();
                if (kept_n == 0)
                    await_word(make_word(ptks_pkg::KIND_RANKED, 1'b0, floor_v,
                                         '0, '0, 1'b0, 1'b1));
                else
                begin
                    srt_s = kept_score;
                    srt_d = kept_doc;
                    for (int i = 0; i < kept_n; i++)
                    begin
                        b = i;
                        for (int j = i + 1; j < kept_n; j++)
                            if (pair_below(srt_s[b], srt_d[b], srt_s[j], srt_d[j]))
                                b = j;
                        ts = srt_s[i];
                        td = srt_d[i];
                        srt_s[i] = srt_s[b];
                        srt_d[i] = srt_d[b];
                        srt_s[b] = ts;
                        srt_d[b] = td;
                        await_word(make_word(ptks_pkg::KIND_RANKED, 1'b0, floor_v,
                                             srt_s[i], srt_d[i], 1'b1,
                                             i == kept_n - 1));
                    end
                end
                kept_n = 0;
                foreach (seen_doc[d])
                    seen_doc[d] = 1'b0;
                finishes_taken++;
            end
        endcase
    endtask

    task automatic show_word(string tag, ptks_pkg::result_t r);
        $display("%s kind=%0d flag=%0b thr=%h score=%h doc=%h valid=%0b last=%0b",
                 tag, r.kind, r.flag, r.threshold, r.rank_score, r.rank_doc,
                 r.entry_valid, r.last);
    endtask

    task automatic check_word(ptks_pkg::result_t got);
        ptks_pkg::result_t want;
        if (awaited_words.size() == 0)
        begin
            fault_count++;
            if (fault_count <= 10)
                show_word("result word with nothing awaited:", got);
        end
        else
        begin
            want = awaited_words.pop_front();
            if (got.kind !== want.kind || got.flag !== want.flag
                || got.threshold !== want.threshold || got.rank_score !== want.rank_score
                || got.rank_doc !== want.rank_doc || got.entry_valid !== want.entry_valid
                || got.last !== want.last)
            begin
                fault_count++;
                if (fault_count <= 10)
                begin
                    $display("result word %0d mismatch", words_checked);
                    show_word("  expected", want);
                    show_word("  actual  ", got);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= '0;
            gap_left      <= 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                track_query(item_ch.data);
                items_taken++;
            end
            if (!item_ch.valid || item_ch.ready)
            begin
                if (gap_left != 0)
                begin
                    gap_left      <= gap_left - 1;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_words.size() != 0)
                begin
                    item_ch.data  <= pending_words.pop_front();
                    item_ch.valid <= 1'b1;
                    gap_left      <= draw_wait();
                end
                else
                    item_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
            words_checked   <= 0;
        end
        else
        begin
            stall_next = (stall_left > 0) ? stall_left - 1 : 0;
            if (result_ch.valid && result_ch.ready)
            begin
                check_word(result_ch.data);
                words_checked <= words_checked + 1;
                stall_next = draw_wait();
            end
            stall_left      <= stall_next;
            result_ch.ready <= (stall_next == 0) && (hold_left == 0);
        end
    end

    // One long back-pressure episode so the block fills up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_armed && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    initial
    begin
        for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++)
            @(posedge clk);
        $display("timeout after %0d cycles", RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic queue_word(logic [ptks_pkg::OP_W-1:0] op,
                              logic [ptks_pkg::SCORE_W-1:0] score,
                              logic [ptks_pkg::DOC_W-1:0] doc);
        ptks_pkg::item_t w;
        w.op     = op;
        w.score  = score;
        w.doc_id = doc;
        pending_words = {pending_words, w};
    endtask

    function automatic logic [ptks_pkg::SCORE_W-1:0] pick_score();
        logic [ptks_pkg::SCORE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = '1;
                    2: v = 32'h8000_0000;
                    default: v = 32'h7FFF_FFFF;
                endcase
            end
            // A coarse grid of scores makes ties between documents common.
            1, 2, 3, 4: v = ptks_pkg::SCORE_W'($urandom_range(0, 7)) << 14;
            default: v = $urandom();
        endcase
        return v;
    endfunction

    function automatic logic [ptks_pkg::DOC_W-1:0] pick_doc();
        logic [ptks_pkg::DOC_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = $urandom_range(0, 1) ? '1 : '0;
            1, 2, 3: v = ptks_pkg::DOC_W'($urandom_range(0, 65535));
            default: v = ptks_pkg::DOC_W'($urandom_range(0, 31));
        endcase
        return v;
    endfunction

    // One query: claim each document, usually check a block bound and offer its score.
    task automatic queue_query(output int added);
        int                         n_docs;
        logic [ptks_pkg::DOC_W-1:0] doc;
        added  = 0;
        n_docs = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 10);
        for (int i = 0; i < n_docs; i++)
        begin
            if ($urandom_range(0, 6) == 0)
            begin
                queue_word(ptks_pkg::OP_W'($urandom_range(0, 3)), pick_score(), pick_doc());
                added++;
            end
            doc = pick_doc();
            queue_word(ptks_pkg::OP_CLAIM, '0, doc);
            added++;
            if ($urandom_range(0, 9) < 7)
            begin
                queue_word(ptks_pkg::OP_CHECK, pick_score(), '0);
                added++;
            end
            if ($urandom_range(0, 9) < 8)
            begin
                queue_word(ptks_pkg::OP_OFFER, pick_score(), doc);
                added++;
            end
        end
        if ($urandom_range(0, 9) < 8)
        begin
            queue_word(ptks_pkg::OP_FINISH, '0, '0);
            added++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_words.size() != 0 || item_ch.valid || awaited_words.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic load_top_count(logic [ptks_pkg::K_W-1:0] k);
        @(posedge clk);
        cfg_wdata <= k;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        top_k = k;
    endtask

    initial
    begin
        int added;
        int phase_count;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Default k: empty store, repeated claims, extreme scores and documents.
        queue_word(ptks_pkg::OP_CHECK, '0, '0);
        queue_word(ptks_pkg::OP_FINISH, '0, '0);
        queue_word(ptks_pkg::OP_CLAIM, '0, 16'h0000);
        queue_word(ptks_pkg::OP_CLAIM, '0, 16'h0000);
        queue_word(ptks_pkg::OP_CLAIM, '0, 16'hFFFF);
        queue_word(ptks_pkg::OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF);
        queue_word(ptks_pkg::OP_OFFER, '0, 16'h0000);
        queue_word(ptks_pkg::OP_CHECK, '0, '0);
        queue_word(ptks_pkg::OP_CHECK, 32'hFFFF_FFFF, '0);
        queue_word(ptks_pkg::OP_FINISH, '0, '0);
        queue_word(ptks_pkg::OP_CLAIM, '0, 16'h0000);
        wait_drained();

        // k of two: equal scores are ordered by document, and replacing needs a greater score.
        load_top_count(5'd2);
        queue_word(ptks_pkg::OP_OFFER, 32'h0005_0000, 16'd10);
        queue_word(ptks_pkg::OP_OFFER, 32'h0005_0000, 16'd20);
        queue_word(ptks_pkg::OP_OFFER, 32'h0005_0000, 16'd15);
        queue_word(ptks_pkg::OP_CHECK, 32'h0005_0000, '0);
        queue_word(ptks_pkg::OP_CHECK, 32'h0004_FFFF, '0);
        queue_word(ptks_pkg::OP_OFFER, 32'h0006_0000, 16'd1);
        queue_word(ptks_pkg::OP_OFFER, 32'h8000_0000, 16'hAAAA);
        queue_word(ptks_pkg::OP_FINISH, '0, '0);
        queue_word(ptks_pkg::OP_CLAIM, '0, 16'h5555);
        queue_word(ptks_pkg::OP_OFFER, 32'h5555_5555, 16'h5555);
        queue_word(ptks_pkg::OP_CHECK, 32'hAAAA_AAAA, '0);
        queue_word(ptks_pkg::OP_FINISH, '0, '0);
        wait_drained();

        for (int p = 0; p < $size(K_PLAN); p++)
        begin
            load_top_count(K_PLAN[p]);
            idle_on     = (p % 3) != 2;
            phase_count = 0;
            while (phase_count < PHASE_WORDS)
            begin
                queue_query(added);
                phase_count += added;
            end
            // Leave a store with entries open so the next, smaller k applies mid-query.
            if (K_PLAN[p] == 5'd16)
                repeat (14) queue_word(ptks_pkg::OP_OFFER, pick_score(), pick_doc());
            if (p == 3)
                hold_armed = 1'b1;
            wait_drained();
        end

        $display("Run took %0d input words and checked %0d result words in %0d cycles,",
                 items_taken, words_checked, cycle_count);
        $display("over %0d finished queries and %0d values of k; %0d words mismatched.",
                 finishes_taken, $size(K_PLAN) + 2, fault_count);
        if (fault_count == 0 && awaited_words.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
